// ----- src/scsa_pkg.sv -----
// Package for the size class slab allocator: sizes, codes and word structs.
// Used by every module in src; depends on nothing.
package scsa_pkg;
  localparam int unsigned NumPages   = 64;
  localparam int unsigned PageW      = $clog2(NumPages);
  localparam int unsigned NumClasses = 8;
  localparam int unsigned LinkDepth  = NumPages * 256;
  localparam int unsigned LinkAw     = PageW + 8;

  typedef enum logic [1:0] {
    StOk = 2'd0, StTooLarge = 2'd1, StNoPages = 2'd2, StIgnored = 2'd3
  } status_e;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  typedef struct packed {
    logic        command;
    logic [11:0] request_bytes;
    logic [17:0] byte_address;
  } req_t;

  typedef struct packed {
    logic [17:0] slot_address;
    logic [11:0] slot_bytes;
    logic [1:0]  status;
  } rsp_t;

  // link memory port, driven by the sequencer
  typedef struct packed {
    logic              we;
    logic [LinkAw-1:0] addr;
    logic [8:0]        wdata;
  } link_cmd_t;

  // slot size of class c
  function automatic logic [11:0] class_slot(input logic [2:0] c);
    class_slot = 12'd16 << c;
  endfunction

  // first slot index after the header area
  function automatic logic [7:0] first_idx(input logic [2:0] c);
    first_idx = (c == 3'd0) ? 8'd2 : 8'd1;
  endfunction

  // last slot index of a page
  function automatic logic [7:0] last_idx(input logic [2:0] c);
    last_idx = 8'(9'd256 >> c) - 8'd1;
  endfunction
endpackage

// ----- src/scsa_link_ram.sv -----
// Slot link memory: one write or read port, registered read data.
// Depends on scsa_pkg.
module scsa_link_ram (
  input  logic                clk_i,
  input  scsa_pkg::link_cmd_t cmd_i,
  output logic [8:0]          rdata_o
);
  logic [8:0] mem [scsa_pkg::LinkDepth];

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[cmd_i.addr] <= cmd_i.wdata;
    end
    rdata_o <= mem[cmd_i.addr];
  end
endmodule

// ----- src/size_class_slab_allocator.sv -----
// Top level of the slab allocator: sequencer, page table and class heads.
// Depends on scsa_pkg and scsa_link_ram.
//
//  channel | handshake         | word
//  req     | start_i / busy_o  | req_i  (scsa_pkg::req_t)
//  rsp     | done_o (strobe)   | rsp_o  (scsa_pkg::rsp_t)
//
// A word is taken when start_i is high and busy_o low. Allocate hitting a page
// follows links in the chain until it finds a page with free slots. Allocate on a
// fresh page also carves its links (up to 254) through the single link memory
// port. Reset clears the page flags and heads at once; the link memory is never
// cleared. The result strobe cannot stall.
module size_class_slab_allocator (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  scsa_pkg::req_t  req_i,
  output logic            busy_o,
  output logic            done_o,
  output scsa_pkg::rsp_t  rsp_o
);
  localparam int unsigned PW = scsa_pkg::PageW;

  typedef enum logic [3:0] {
    SIdle, SWalk, SHop, SCarve, SPopRd, SPopWait, SPop, SFree, SDone
  } state_e;

  state_e state_q;
  scsa_pkg::req_t req_q;

  // class heads
  logic [scsa_pkg::NumClasses-1:0] cl_valid_q;
  logic [PW-1:0] cl_head_q [scsa_pkg::NumClasses];
  // page flags
  logic [scsa_pkg::NumPages-1:0] pg_used_q, pg_nv_q, pg_fv_q;
  logic [PW:0]   fresh_q;

  // page table memories, registered read
  logic [2:0]    cls_mem  [scsa_pkg::NumPages];
  logic [PW-1:0] nxt_mem  [scsa_pkg::NumPages];
  logic [7:0]    head_mem [scsa_pkg::NumPages];
  logic [2:0]    cls_rd;
  logic [PW-1:0] nxt_rd;
  logic [7:0]    head_rd;
  logic [PW-1:0] head_ra;
  logic          head_we;
  logic [PW-1:0] head_wa;
  logic [7:0]    head_wd;

  logic [2:0]    k_q;
  logic [PW-1:0] p_q;
  logic [7:0]    i_q;
  logic          walk_q;   // empty chain on entry to SWalk; check-and-write step of a free

  scsa_pkg::link_cmd_t link_cmd;
  logic [8:0] link_rd;

  scsa_link_ram u_links (.clk_i(clk_i), .cmd_i(link_cmd), .rdata_o(link_rd));

  // size to class
  logic [2:0] k_d;
  always_comb begin
    k_d = 3'd7;
    for (int c = 6; c >= 0; c--) begin
      if ({1'b0, req_i.request_bytes} <= 13'(scsa_pkg::class_slot(3'(c)))) k_d = 3'(c);
    end
  end

  // free decode
  logic [5:0] f_page;
  logic [11:0] f_off;
  logic [2:0] f_cls;
  logic [7:0] f_idx;
  logic f_ok;
  assign f_page = req_q.byte_address[17:12];
  assign f_off  = req_q.byte_address[11:0];
  assign f_cls  = cls_rd;
  assign f_idx  = 8'(f_off >> ({1'b0, f_cls} + 4'd4));
  assign f_ok   = pg_used_q[PW'(f_page)] &&
                  (f_off >= ((f_cls == 3'd0) ? 12'd32 : scsa_pkg::class_slot(f_cls)));

  // fresh page taken this cycle
  logic take_fresh;
  assign take_fresh = (state_q == SWalk) && (walk_q || (!pg_fv_q[p_q] && !pg_nv_q[p_q])) &&
                      (fresh_q < (PW+1)'(scsa_pkg::NumPages));

  // free head write port
  always_comb begin
    head_we = 1'b0;
    head_wa = p_q;
    head_wd = link_rd[7:0];
    if (take_fresh) begin
      head_we = 1'b1;
      head_wa = PW'(fresh_q);
      head_wd = scsa_pkg::first_idx(k_q);
    end else if (state_q == SPop) begin
      head_we = 1'b1;
    end else if ((state_q == SFree) && walk_q && f_ok) begin
      head_we = 1'b1;
      head_wa = PW'(f_page);
      head_wd = f_idx;
    end
  end

  assign head_ra = (state_q == SFree) ? PW'(f_page) : p_q;

  // page table memories
  always_ff @(posedge clk_i) begin
    if (take_fresh) begin
      cls_mem[PW'(fresh_q)] <= k_q;
      if (!walk_q) nxt_mem[p_q] <= PW'(fresh_q);
    end
    if (head_we) head_mem[head_wa] <= head_wd;
    cls_rd  <= cls_mem[PW'(f_page)];
    nxt_rd  <= nxt_mem[p_q];
    head_rd <= head_mem[head_ra];
  end

  // link port
  always_comb begin
    link_cmd = '0;
    case (state_q)
      SCarve: begin
        link_cmd.we    = 1'b1;
        link_cmd.addr  = {p_q, i_q};
        link_cmd.wdata = (i_q == scsa_pkg::last_idx(k_q)) ? 9'd0 : {1'b1, i_q + 8'd1};
      end
      SPopWait: link_cmd.addr = {p_q, head_rd};
      SFree: begin
        link_cmd.we    = walk_q && f_ok;
        link_cmd.addr  = {PW'(f_page), f_idx};
        link_cmd.wdata = pg_fv_q[PW'(f_page)] ? {1'b1, head_rd} : 9'd0;
      end
      default: link_cmd = '0;
    endcase
  end

  assign busy_o = (state_q != SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      cl_valid_q <= '0;
      pg_used_q  <= '0;
      pg_nv_q    <= '0;
      pg_fv_q    <= '0;
      fresh_q    <= '0;
      done_o     <= 1'b0;
      walk_q     <= 1'b0;
    end else begin
      done_o <= 1'b0;
      walk_q <= 1'b0;
      case (state_q)
        SIdle: if (start_i) begin
          req_q  <= req_i;
          k_q    <= k_d;
          if (req_i.command == scsa_pkg::CmdFree) begin
            state_q <= SFree;
          end else if (req_i.request_bytes > 12'd2048) begin
            rsp_o   <= {18'd0, 12'd0, scsa_pkg::StTooLarge};
            state_q <= SDone;
          end else if (cl_valid_q[k_d]) begin
            p_q     <= cl_head_q[k_d];
            state_q <= SWalk;
          end else begin
            p_q     <= '0;
            state_q <= SWalk;
            walk_q  <= 1'b1;   // empty chain: go fresh
          end
        end
        // walk the chain, through SWalk and SHop for each page
        SWalk: begin
          if (!walk_q && pg_fv_q[p_q]) begin
            state_q <= SPopRd;
          end else if (!walk_q && pg_nv_q[p_q]) begin
            state_q <= SHop;
          end else if (fresh_q >= (PW+1)'(scsa_pkg::NumPages)) begin
            rsp_o   <= {18'd0, 12'd0, scsa_pkg::StNoPages};
            state_q <= SDone;
          end else begin
            // take a fresh page and hook it in
            if (walk_q) begin
              cl_valid_q[k_q] <= 1'b1;
              cl_head_q[k_q]  <= PW'(fresh_q);
            end else begin
              pg_nv_q[p_q] <= 1'b1;
            end
            p_q <= PW'(fresh_q);
            pg_used_q[PW'(fresh_q)] <= 1'b1;
            pg_fv_q[PW'(fresh_q)]   <= 1'b1;
            fresh_q <= fresh_q + 1'b1;
            i_q     <= scsa_pkg::first_idx(k_q);
            state_q <= SCarve;
          end
        end
        SHop: begin
          p_q     <= nxt_rd;
          state_q <= SWalk;
        end
        // write one link a cycle
        SCarve: begin
          if (i_q == scsa_pkg::last_idx(k_q)) state_q <= SPopRd;
          i_q <= i_q + 8'd1;
        end
        SPopRd:   state_q <= SPopWait;
        SPopWait: state_q <= SPop;
        SPop: begin
          pg_fv_q[p_q] <= link_rd[8];
          rsp_o <= {18'({p_q, 12'd0}) + 18'({head_rd, 4'd0} << k_q),
                    scsa_pkg::class_slot(k_q), scsa_pkg::StOk};
          state_q <= SDone;
        end
        // first step reads the page table, the next checks and writes the link
        SFree: begin
          if (!walk_q) begin
            walk_q <= 1'b1;
          end else if (!f_ok) begin
            rsp_o   <= {18'd0, 12'd0, scsa_pkg::StIgnored};
            state_q <= SDone;
          end else begin
            pg_fv_q[PW'(f_page)] <= 1'b1;
            rsp_o <= {18'({f_page, 12'd0}) + 18'({f_idx, 4'd0} << f_cls),
                      scsa_pkg::class_slot(f_cls), scsa_pkg::StOk};
            state_q <= SDone;
          end
        end
        SDone: begin
          done_o  <= 1'b1;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // result strobe only after a finished job
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == SDone)) else $error("stray result");
  a_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= (PW+1)'(scsa_pkg::NumPages)) else $error("page count overrun");
  a_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != scsa_pkg::StOk |-> rsp_o.slot_bytes == 12'd0)
    else $error("size on failed result");
endmodule
